// ===== rtl/pcpa_pkg.sv =====
`timescale 1ns / 1ps

package pcpa_pkg;

   // result status codes
   localparam logic [1:0] ST_ALLOC   = 2'd0;
   localparam logic [1:0] ST_FREED   = 2'd1;
   localparam logic [1:0] ST_OOM     = 2'd2;
   localparam logic [1:0] ST_BADFREE = 2'd3;

   // configuration register indexes
   localparam logic CSR_REGION_START = 1'b0;
   localparam logic CSR_REGION_END   = 1'b1;

   // register reset values
   localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
   localparam logic [31:0] REGION_END_RST   = 32'h8800_0000;

   // controller to datapath commands
   typedef struct packed {
      logic       load_req;   // capture the request
      logic       sel_scan;   // head port addresses the scan CPU
      logic       push;       // commit a valid free
      logic       rd_head;    // read the link of the selected head
      logic       pop_own;    // requester head takes the link just read
      logic       take_scan;  // same, after a steal
      logic       scan_init;  // start the scan at id + 1
      logic       scan_next;  // advance the scan
      logic       rsp_load;   // load the response registers
      logic [1:0] rsp_status;
   } pcpa_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_free;
      logic free_ok;
      logic head_valid;  // selected list is non-empty
      logic scan_last;
      logic no_peer;     // single CPU, nothing to steal from
   } pcpa_sts_type;

endpackage

// ===== rtl/per_cpu_page_allocator_with_steal_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                      Transfer when
// request   in         req_opcode, req_cpu_id, req_free_address  start & !busy
// response  out        rsp_status, rsp_page_address, rsp_stolen, rsp_valid
//                      rsp_source_cpu
// config    in         csr_index, csr_wr_data                    csr_wr_en
//
// A free is answered from the execute state; an allocation pops its own list
// if non-empty, else scans the other CPUs, steals the first non-empty list
// or reports out of memory. The steal scan tests one CPU's list head per
// cycle; each pop costs one registered read of the next-link memory.
// Reset is synchronous: every list empty, region registers at their defaults.
// The response is held for one cycle only; the receiver cannot stall it, and a
// new request may transfer in the cycle the response is shown.
module per_cpu_page_allocator_with_steal_core #(
   parameter int NUM_CPUS   = 8,      // 1 to 8
   parameter int MAX_PAGES  = 32768,  // 1 to 65535
   parameter int PAGE_BYTES = 4096    // power of two, 256 to 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [2:0]  req_cpu_id,
   input  logic [31:0] req_free_address,
   // response
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_page_address,
   output logic        rsp_stolen,
   output logic [2:0]  rsp_source_cpu,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   // Command and status between controller and datapath. The controller
   // sequences execute, pop, scan and take; the datapath holds the heads,
   // the link memory and the response registers.
   pcpa_pkg::pcpa_cmd_type cmd;
   pcpa_pkg::pcpa_sts_type sts;

   pcpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .sts      (sts),
      .cmd      (cmd)
   );

   // Links are stored with a valid bit in front of the page index, so the
   // null marker never needs an index code of its own.
   pcpa_dp #(
      .NUM_CPUS  (NUM_CPUS),
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_cpu_id      (req_cpu_id),
      .req_free_address(req_free_address),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_page_address(rsp_page_address),
      .rsp_stolen      (rsp_stolen),
      .rsp_source_cpu  (rsp_source_cpu)
   );

endmodule

// ===== rtl/pcpa_ram.sv =====
`timescale 1ns / 1ps

module pcpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcpa_ctrl.sv =====
`timescale 1ns / 1ps

module pcpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  pcpa_pkg::pcpa_sts_type sts,
   output pcpa_pkg::pcpa_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_TAKE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_free) begin
               cmd.rsp_load = 1'b1;
               if (sts.free_ok) begin
                  cmd.push       = 1'b1;
                  cmd.rsp_status = pcpa_pkg::ST_FREED;
               end else begin
                  cmd.rsp_status = pcpa_pkg::ST_BADFREE;
               end
               state_in = S_IDLE;
            end else if (sts.head_valid) begin
               cmd.rd_head = 1'b1;
               state_in    = S_POP;
            end else if (sts.no_peer) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = pcpa_pkg::ST_OOM;
               state_in       = S_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_POP: begin
            cmd.pop_own    = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = pcpa_pkg::ST_ALLOC;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            cmd.sel_scan = 1'b1;
            if (sts.head_valid) begin
               cmd.rd_head = 1'b1;
               state_in    = S_TAKE;
            end else if (sts.scan_last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = pcpa_pkg::ST_OOM;
               state_in       = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_TAKE: begin
            cmd.take_scan  = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = pcpa_pkg::ST_ALLOC;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a response always follows a working cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) != S_IDLE)
      else $error("response without a preceding working cycle");

   a_pop_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> $past(state_ff) == S_EXEC)
      else $error("pop state entered from outside execute");

   a_take_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAKE) |-> $past(state_ff) == S_SCAN)
      else $error("take state entered without a scan hit");

endmodule

// ===== rtl/pcpa_dp.sv =====
`timescale 1ns / 1ps

module pcpa_dp #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_opcode,
   input  logic [2:0]             req_cpu_id,
   input  logic [31:0]            req_free_address,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wr_data,
   input  pcpa_pkg::pcpa_cmd_type  cmd,
   output pcpa_pkg::pcpa_sts_type  sts,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_page_address,
   output logic                   rsp_stolen,
   output logic [2:0]             rsp_source_cpu
);

   localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam int PB_LOG = $clog2(PAGE_BYTES);
   localparam logic [31:0] PB_MASK   = 32'(PAGE_BYTES - 1);
   localparam logic [31:0] PAGES_LIM = 32'(MAX_PAGES);
   localparam logic [4:0]  NCPU_5    = 5'(NUM_CPUS);
   localparam logic [CPU_W-1:0] CPU_LAST = CPU_W'(NUM_CPUS - 1);

   // configuration
   logic [31:0] region_start_ff, region_end_ff;

   // captured request
   logic            op_ff;
   logic [CPU_W-1:0] id_ff;
   logic [31:0]     addr_ff;

   // list heads: valid bit plus page index per CPU
   logic             head_valid_ff [NUM_CPUS];
   logic [IDX_W-1:0] head_idx_ff   [NUM_CPUS];

   logic [CPU_W-1:0] scan_cpu_ff, scan_left_ff;
   logic [IDX_W-1:0] pick_idx_ff;

   logic [1:0]  status_ff;
   logic [31:0] page_ff;
   logic        stolen_ff;
   logic [2:0]  src_ff;

   logic [4:0]       id_mod;
   logic [CPU_W-1:0] port_cpu;
   logic             sel_valid;
   logic [IDX_W-1:0] sel_idx;
   logic [31:0]      base, diff, idx_wide;
   logic             free_ok;
   logic [IDX_W-1:0] free_idx;
   logic [LINK_W-1:0] rd_link;
   logic [CPU_W-1:0] id_next, scan_next;
   logic              link_wr_en;
   logic [IDX_W-1:0]  link_wr_addr;
   logic [LINK_W-1:0] link_wr_data;

   // fold cpu_id into range by repeated subtraction
   always_comb begin
      id_mod = {2'b00, req_cpu_id};
      for (int i = 0; i < 7; i++) begin
         if (id_mod >= NCPU_5) begin
            id_mod = id_mod - NCPU_5;
         end
      end
   end

   assign port_cpu  = cmd.sel_scan ? scan_cpu_ff : id_ff;
   assign sel_valid = head_valid_ff[port_cpu];
   assign sel_idx   = head_idx_ff[port_cpu];

   // free checks against the captured address
   assign base     = region_start_ff & ~PB_MASK;
   assign diff     = addr_ff - base;
   assign idx_wide = diff >> PB_LOG;
   assign free_ok  = ((addr_ff & PB_MASK) == 32'd0) && (addr_ff >= region_start_ff) &&
                     (addr_ff < region_end_ff) && (idx_wide < PAGES_LIM);
   assign free_idx = idx_wide[IDX_W-1:0];

   assign id_next   = (id_ff == CPU_LAST) ? '0 : id_ff + 1'b1;
   assign scan_next = (scan_cpu_ff == CPU_LAST) ? '0 : scan_cpu_ff + 1'b1;

   // a steal ends the stolen head's link, cutting it off any list that shares it
   assign link_wr_en   = cmd.push | cmd.take_scan;
   assign link_wr_addr = cmd.take_scan ? pick_idx_ff : free_idx;
   assign link_wr_data = cmd.take_scan ? '0 : {sel_valid, sel_idx};

   pcpa_ram #(
      .WIDTH(LINK_W),
      .DEPTH(MAX_PAGES)
   ) u_links (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(link_wr_addr),
      .wr_data(link_wr_data),
      .rd_en  (cmd.rd_head),
      .rd_addr(sel_idx),
      .rd_data(rd_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= pcpa_pkg::REGION_START_RST;
         region_end_ff   <= pcpa_pkg::REGION_END_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pcpa_pkg::CSR_REGION_START: region_start_ff <= csr_wr_data;
            pcpa_pkg::CSR_REGION_END:   region_end_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_valid_ff[c] <= 1'b0;
         end
      end else begin
         if (cmd.push) begin
            head_valid_ff[id_ff] <= 1'b1;
         end
         if (cmd.rd_head && cmd.sel_scan) begin
            head_valid_ff[scan_cpu_ff] <= 1'b0;
         end
         if (cmd.pop_own || cmd.take_scan) begin
            head_valid_ff[id_ff] <= rd_link[IDX_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_opcode;
         id_ff   <= id_mod[CPU_W-1:0];
         addr_ff <= req_free_address;
      end
      if (cmd.push) begin
         head_idx_ff[id_ff] <= free_idx;
      end
      if (cmd.pop_own || cmd.take_scan) begin
         head_idx_ff[id_ff] <= rd_link[IDX_W-1:0];
      end
      if (cmd.rd_head) begin
         pick_idx_ff <= sel_idx;
      end
      if (cmd.scan_init) begin
         scan_cpu_ff  <= id_next;
         scan_left_ff <= CPU_LAST;
      end else if (cmd.scan_next) begin
         scan_cpu_ff  <= scan_next;
         scan_left_ff <= scan_left_ff - 1'b1;
      end
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == pcpa_pkg::ST_ALLOC) begin
            page_ff   <= base + (32'(pick_idx_ff) << PB_LOG);
            stolen_ff <= cmd.take_scan;
            src_ff    <= cmd.take_scan ? 3'(scan_cpu_ff) : 3'(id_ff);
         end else begin
            page_ff   <= 32'd0;
            stolen_ff <= 1'b0;
            src_ff    <= 3'd0;
         end
      end
   end

   assign sts.is_free    = op_ff;
   assign sts.free_ok    = free_ok;
   assign sts.head_valid = sel_valid;
   assign sts.scan_last  = (scan_left_ff == CPU_W'(1));
   assign sts.no_peer    = (NUM_CPUS == 1);

   assign rsp_status       = status_ff;
   assign rsp_page_address = page_ff;
   assign rsp_stolen       = stolen_ff;
   assign rsp_source_cpu   = src_ff;

   // a steal leaves the victim list empty
   a_victim_emptied: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_head && cmd.sel_scan) |=> !head_valid_ff[$past(scan_cpu_ff)])
      else $error("victim list still valid after steal");

endmodule
